/* sv/tws_pkg.sv */
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants and types for the track word stream validator.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS;
  localparam int DECL_W     = 15;
  localparam int CMP_W      = (CNT_W > DECL_W) ? CNT_W : DECL_W;
  localparam int SAT_W      = (CNT_W > 16) ? CNT_W : 16;
  localparam int SCORE_W    = CNT_W + 3;
  localparam int NREAD      = 4;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_MARKER = 2'd1;
  localparam logic [1:0] PH_TIME   = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  localparam logic signed [15:0] W_AMP_MARK  = -16'sd1;
  localparam logic signed [15:0] W_FREQ_MARK = -16'sd2;
  localparam logic signed [15:0] W_TRACK_END = 16'sd32767;

  localparam logic [SCORE_W-1:0] HDR_BONUS = SCORE_W'(20);

  // verdict of one reading, valid on the cycle an item is processed
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] amp;
  } rd_status_t;

  typedef struct packed {
    logic        valid_res;
    logic        big_endian;
    logic        has_header;
    logic [15:0] partial_pairs;
  } verdict_t;

endpackage

/* sv/track_word_stream_validator.sv */
// ----------------------------------------------------------------------------
// track_word_stream_validator
// Checks a word stream against four byte-order/header readings at once.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one 16-bit word per item, two bytes in file order,
//   s_tlast marks the final word of a stream. Master channel m_*: one
//   verdict item per stream, sent only for the last word.
//   An item is registered on input, then the four readers and the picker
//   update together; a verdict appears on m_tvalid once its last word has
//   passed the input register and been stored in the output register.
//   Throughput is one word per cycle; the only stall comes from a verdict
//   still held in the output register when the next last word is ready.
//   Non-last words never wait on the master side.
//   After the last word all reader state returns to its start, so the next
//   word opens a new stream. rst (synchronous) empties both registers and
//   restarts all readers.
// ----------------------------------------------------------------------------
module track_word_stream_validator import tws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] first_byte, [15:8] second_byte
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] valid_res, [1] big_endian, [2] has_header,
                                 // [18:3] partial_pairs, [23:19] zero
);

  logic        in_valid;
  logic [15:0] in_data;
  logic        in_last;
  logic        process;
  logic [1:0]  words_seen, words_seen_next;
  logic signed [15:0] wle, wbe;
  rd_status_t  st [NREAD];
  verdict_t    verdict;
  logic        out_valid;
  verdict_t    out_data;

  assign process  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign wle = in_data;
  assign wbe = {in_data[7:0], in_data[15:8]};
  assign words_seen_next = (words_seen == 2'd3) ? words_seen : words_seen + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen <= '0;
    end else if (process) begin
      words_seen <= in_last ? 2'd0 : words_seen_next;
    end
  end

  // reading order: LE header, LE plain, BE header, BE plain
  tws_reader u_rd0 (.clk, .rst, .en(process), .word(wle), .last(in_last), .hdr(1'b1),
                    .len_ok(words_seen_next[1]), .status(st[0]));
  tws_reader u_rd1 (.clk, .rst, .en(process), .word(wle), .last(in_last), .hdr(1'b0),
                    .len_ok(words_seen_next[1]), .status(st[1]));
  tws_reader u_rd2 (.clk, .rst, .en(process), .word(wbe), .last(in_last), .hdr(1'b1),
                    .len_ok(words_seen_next[1]), .status(st[2]));
  tws_reader u_rd3 (.clk, .rst, .en(process), .word(wbe), .last(in_last), .hdr(1'b0),
                    .len_ok(words_seen_next[1]), .status(st[3]));

  tws_pick u_pick (.st(st), .verdict(verdict));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_last) begin
      out_data <= verdict;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data.partial_pairs, out_data.has_header,
                     out_data.big_endian, out_data.valid_res};

endmodule

/* sv/tws_reader.sv */
// ----------------------------------------------------------------------------
// tws_reader
// One candidate reading: track grammar state machine and track counters.
// ----------------------------------------------------------------------------
module tws_reader import tws_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,        // item processed this cycle
  input  logic signed [15:0] word,
  input  logic               last,
  input  logic               hdr,       // reading expects a header word
  input  logic               len_ok,    // stream has at least two words
  output rd_status_t         status
);

  logic [1:0]        phase, phase_next;
  logic [14:0]       prev_time, prev_time_next;
  logic              track_has_point, track_has_point_next;
  logic [CNT_W-1:0]  amp_tracks, amp_tracks_next;
  logic [CNT_W-1:0]  freq_tracks, freq_tracks_next;
  logic [DECL_W-1:0] declared_count, declared_count_next;
  logic              failed, failed_next;

  always_comb begin
    phase_next           = phase;
    prev_time_next       = prev_time;
    track_has_point_next = track_has_point;
    amp_tracks_next      = amp_tracks;
    freq_tracks_next     = freq_tracks;
    declared_count_next  = declared_count;
    failed_next          = failed;
    if (!failed) begin
      case (phase)
        PH_HEADER: begin
          if (word[15] || word == 16'sd0 || word == W_TRACK_END) begin
            failed_next = 1'b1;
          end else begin
            declared_count_next = word[DECL_W-1:0];
            phase_next          = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (word == W_AMP_MARK || word == W_FREQ_MARK) begin
            if (word == W_AMP_MARK) begin
              if (amp_tracks != '1) amp_tracks_next = amp_tracks + CNT_W'(1);
            end else begin
              if (freq_tracks != '1) freq_tracks_next = freq_tracks + CNT_W'(1);
            end
            track_has_point_next = 1'b0;
            prev_time_next       = '0;
            phase_next           = PH_TIME;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_TIME: begin
          if (word == W_TRACK_END) begin
            if (!track_has_point) failed_next = 1'b1;
            else phase_next = PH_MARKER;
          end else if (word[15]) begin
            failed_next = 1'b1;
          end else if (track_has_point && word[14:0] < prev_time) begin
            failed_next = 1'b1;
          end else begin
            prev_time_next = word[14:0];
            phase_next     = PH_VALUE;
          end
        end
        default: begin
          if (word[15]) begin
            failed_next = 1'b1;
          end else begin
            track_has_point_next = 1'b1;
            phase_next           = PH_TIME;
          end
        end
      endcase
    end
  end

  always_comb begin
    status.ok  = !failed_next && phase_next == PH_MARKER && len_ok &&
                 amp_tracks_next == freq_tracks_next && amp_tracks_next != '0 &&
                 (!hdr || CMP_W'(declared_count_next) == CMP_W'(amp_tracks_next));
    status.amp = amp_tracks_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last)) begin
      phase           <= hdr ? PH_HEADER : PH_MARKER;
      prev_time       <= '0;
      track_has_point <= 1'b0;
      amp_tracks      <= '0;
      freq_tracks     <= '0;
      declared_count  <= '0;
      failed          <= 1'b0;
    end else if (en) begin
      phase           <= phase_next;
      prev_time       <= prev_time_next;
      track_has_point <= track_has_point_next;
      amp_tracks      <= amp_tracks_next;
      freq_tracks     <= freq_tracks_next;
      declared_count  <= declared_count_next;
      failed          <= failed_next;
    end
  end

endmodule

/* sv/tws_pick.sv */
// ----------------------------------------------------------------------------
// tws_pick
// Chooses the best-scoring accepting reading; earlier readings win ties.
// ----------------------------------------------------------------------------
module tws_pick import tws_pkg::*; (
  input  rd_status_t st [NREAD],
  output verdict_t   verdict
);

  logic [SCORE_W-1:0] score     [NREAD];
  logic [SCORE_W-1:0] best_score;
  logic [1:0]         best;
  logic               found;
  logic [SAT_W-1:0]   amp_ext;

  always_comb begin
    // common base of 100 dropped; readings 0 and 2 carry a header
    for (int r = 0; r < NREAD; r++) begin
      score[r] = {1'b0, st[r].amp, 2'b00} + (((r & 1) == 0) ? HDR_BONUS : '0);
    end
    found      = 1'b0;
    best       = '0;
    best_score = '0;
    for (int r = 0; r < NREAD; r++) begin
      if (st[r].ok && (!found || score[r] > best_score)) begin
        found      = 1'b1;
        best       = r[1:0];
        best_score = score[r];
      end
    end
    amp_ext = SAT_W'(st[best].amp);
    verdict.valid_res     = found;
    verdict.big_endian    = found & best[1];
    verdict.has_header    = found & ~best[0];
    verdict.partial_pairs = !found ? 16'd0 :
                            (amp_ext > SAT_W'(17'h0FFFF)) ? 16'hFFFF : amp_ext[15:0];
  end

endmodule
